@@ rtl/core/cia_pkg.sv @@
package cia_pkg;

  localparam int DataW = 64;
  localparam int HalfW = DataW / 2;
  localparam int ProdW = 2 * DataW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cia_op_t;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } cia_size_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_RANGE    = 2'd1,
    CAUSE_DIV_ZERO = 2'd2
  } cia_cause_t;

  // per-item info that travels down the pipe next to the operands
  typedef struct packed {
    cia_op_t           op;
    cia_size_t         size;
    logic              sgn;
    logic              neg;
    logic [DataW-1:0]  res;
    cia_cause_t        cause;
  } cia_side_t;

  // ones in the bits of the selected width
  function automatic logic [DataW-1:0] size_mask(cia_size_t s);
    logic [DataW-1:0] m;
    unique case (s)
      SIZE_8:  m = 64'h0000_0000_0000_00ff;
      SIZE_16: m = 64'h0000_0000_0000_ffff;
      SIZE_32: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // sign bit of the selected width
  function automatic logic top_bit(logic [DataW-1:0] v, cia_size_t s);
    logic b;
    unique case (s)
      SIZE_8:  b = v[7];
      SIZE_16: b = v[15];
      SIZE_32: b = v[31];
      default: b = v[63];
    endcase
    return b;
  endfunction

  // most negative two's complement pattern of the selected width
  function automatic logic [DataW-1:0] min_pattern(cia_size_t s);
    logic [DataW-1:0] m;
    unique case (s)
      SIZE_8:  m = 64'h0000_0000_0000_0080;
      SIZE_16: m = 64'h0000_0000_0000_8000;
      SIZE_32: m = 64'h0000_0000_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/checked_integer_alu_core.sv @@
// Overflow-checked integer ALU: add, subtract, multiply or truncating divide on
// 8, 16, 32 or 64-bit signed or unsigned operands. A beat is taken whenever start
// is high; busy never rises, so one beat can enter every clock. Every beat gives
// exactly one result, in order, marked by out_valid for one cycle, after the
// input, check, multiplier, divider and output registers, whatever the
// operation. All operations pass through the 64-stage bit-per-stage divider so
// results stay in order; the multiplier is a four-stage partial-product pipe
// ahead of it. Results cannot be held off: the receiver must take each one.
module checked_integer_alu_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [1:0]                  in_size_code,
  input  logic                        in_is_signed,
  input  logic [cia_pkg::DataW-1:0]   in_operand_a,
  input  logic [cia_pkg::DataW-1:0]   in_operand_b,
  output logic                        out_valid,
  output logic [cia_pkg::DataW-1:0]   out_result,
  output logic                        out_overflow,
  output logic [1:0]                  out_cause
);
  import cia_pkg::*;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input stage, operands cut to the selected width
  logic             s1_vld_r;
  cia_op_t          s1_op_r;
  cia_size_t        s1_size_r;
  logic             s1_sgn_r;
  logic [DataW-1:0] s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= cia_op_t'(in_op);
      s1_size_r <= cia_size_t'(in_size_code);
      s1_sgn_r  <= in_is_signed;
      s1_a_r    <= in_operand_a & size_mask(cia_size_t'(in_size_code));
      s1_b_r    <= in_operand_b & size_mask(cia_size_t'(in_size_code));
    end
  end

  // add and subtract with range checks, magnitudes and divide special cases
  logic [DataW-1:0] mask, sum, dif, ma, mb;
  logic             add_ovf, sub_ovf, a_neg, b_neg;
  cia_side_t        s2_side_nxt;

  always_comb begin
    mask    = size_mask(s1_size_r);
    sum     = (s1_a_r + s1_b_r) & mask;
    dif     = (s1_a_r - s1_b_r) & mask;
    add_ovf = s1_sgn_r ? top_bit((s1_a_r ^ sum) & (s1_b_r ^ sum), s1_size_r)
                       : (sum < s1_a_r);
    sub_ovf = s1_sgn_r ? top_bit((s1_a_r ^ s1_b_r) & (s1_a_r ^ dif), s1_size_r)
                       : (s1_a_r < s1_b_r);
    a_neg   = s1_sgn_r & top_bit(s1_a_r, s1_size_r);
    b_neg   = s1_sgn_r & top_bit(s1_b_r, s1_size_r);
    ma      = a_neg ? ((~s1_a_r + 1'b1) & mask) : s1_a_r;
    mb      = b_neg ? ((~s1_b_r + 1'b1) & mask) : s1_b_r;

    s2_side_nxt.op    = s1_op_r;
    s2_side_nxt.size  = s1_size_r;
    s2_side_nxt.sgn   = s1_sgn_r;
    s2_side_nxt.neg   = a_neg ^ b_neg;
    s2_side_nxt.res   = '0;
    s2_side_nxt.cause = CAUSE_NONE;
    case (s1_op_r)
      OP_ADD: begin
        s2_side_nxt.res   = sum;
        s2_side_nxt.cause = add_ovf ? CAUSE_RANGE : CAUSE_NONE;
      end
      OP_SUB: begin
        s2_side_nxt.res   = dif;
        s2_side_nxt.cause = sub_ovf ? CAUSE_RANGE : CAUSE_NONE;
      end
      OP_DIV: begin
        if (s1_b_r == '0) begin
          s2_side_nxt.cause = CAUSE_DIV_ZERO;
        end else if (s1_sgn_r && (s1_a_r == min_pattern(s1_size_r)) && (s1_b_r == mask)) begin
          s2_side_nxt.cause = CAUSE_RANGE;
        end
      end
      default: begin
        s2_side_nxt.cause = CAUSE_NONE;
      end
    endcase
  end

  logic             s2_vld_r;
  cia_side_t        s2_side_r;
  logic [DataW-1:0] s2_ma_r, s2_mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s2_side_nxt;
    s2_ma_r   <= ma;
    s2_mb_r   <= mb;
  end

  // multiplier, then divider
  logic             mul_vld, div_vld;
  cia_side_t        mul_side, div_side;
  logic [DataW-1:0] mul_a, mul_b, div_quot;

  cia_mul_pipe u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .in_side  (s2_side_r),
    .in_a     (s2_ma_r),
    .in_b     (s2_mb_r),
    .out_vld  (mul_vld),
    .out_side (mul_side),
    .out_a    (mul_a),
    .out_b    (mul_b)
  );

  cia_div_pipe u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (mul_vld),
    .in_side     (mul_side),
    .in_dividend (mul_a),
    .in_divisor  (mul_b),
    .out_vld     (div_vld),
    .out_side    (div_side),
    .out_quot    (div_quot)
  );

  // final select, quotient sign applied
  logic [DataW-1:0] out_result_nxt;

  always_comb begin
    out_result_nxt = div_side.res;
    if ((div_side.op == OP_DIV) && (div_side.cause == CAUSE_NONE)) begin
      out_result_nxt = (div_side.neg ? (~div_quot + 1'b1) : div_quot) &
                       size_mask(div_side.size);
    end
  end

  logic             out_vld_r;
  logic [DataW-1:0] out_result_r;
  cia_cause_t       out_cause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    out_cause_r  <= div_side.cause;
  end

  assign out_valid    = out_vld_r;
  assign out_result   = out_result_r;
  assign out_cause    = out_cause_r;
  assign out_overflow = (out_cause_r != CAUSE_NONE);

`ifndef ASSERT_OFF
  // divide errors always come back as zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cause == CAUSE_DIV_ZERO)) |-> (out_result == '0))
    else $error("divide by zero returned nonzero result");

  // a divide by zero can only come from a divide
  a_divzero_op: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && (div_side.cause == CAUSE_DIV_ZERO)) |-> (div_side.op == OP_DIV))
    else $error("divide by zero cause on a non-divide beat");

  // no result bits above the selected width
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld |=> ((out_result & ~size_mask($past(div_side.size))) == '0))
    else $error("result has bits above the operand width");

  // sign of a wrap only set for signed beats
  a_neg_sgn: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_side_r.neg) |-> s2_side_r.sgn)
    else $error("negative flag on an unsigned beat");
`endif

endmodule

@@ rtl/core/cia_mul_pipe.sv @@
module cia_mul_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  cia_pkg::cia_side_t          in_side,
  input  logic [cia_pkg::DataW-1:0]   in_a,
  input  logic [cia_pkg::DataW-1:0]   in_b,
  output logic                        out_vld,
  output cia_pkg::cia_side_t          out_side,
  output logic [cia_pkg::DataW-1:0]   out_a,
  output logic [cia_pkg::DataW-1:0]   out_b
);
  import cia_pkg::*;

  // stage 1: four half-width partial products
  logic             vld1_r, vld2_r, vld3_r, vld4_r;
  cia_side_t        side1_r, side2_r, side3_r, side4_r;
  logic [DataW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic [DataW-1:0] b1_r, b2_r, b3_r, b4_r;
  logic [DataW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [DataW-1:0] pp00_nxt, pp01_nxt, pp10_nxt, pp11_nxt;

  assign pp00_nxt = DataW'(in_a[HalfW-1:0]) * DataW'(in_b[HalfW-1:0]);
  assign pp01_nxt = DataW'(in_a[HalfW-1:0]) * DataW'(in_b[DataW-1:HalfW]);
  assign pp10_nxt = DataW'(in_a[DataW-1:HalfW]) * DataW'(in_b[HalfW-1:0]);
  assign pp11_nxt = DataW'(in_a[DataW-1:HalfW]) * DataW'(in_b[DataW-1:HalfW]);

  // stage 2: middle sum, outer words side by side
  logic [DataW:0]   mid_r, mid_nxt;
  logic [ProdW-1:0] outer_r;

  assign mid_nxt = {1'b0, pp01_r} + {1'b0, pp10_r};

  // stage 3: full product
  logic [ProdW-1:0] prod_r, prod_nxt;

  assign prod_nxt = outer_r + (ProdW'(mid_r) << HalfW);

  // stage 4: wrap, sign and range check
  logic [DataW-1:0] mask, plo, phi, limit, wrapped;
  logic             ovf;
  cia_side_t        side4_nxt;

  always_comb begin
    mask    = size_mask(side3_r.size);
    plo     = prod_r[DataW-1:0];
    phi     = prod_r[ProdW-1:DataW];
    limit   = min_pattern(side3_r.size) - DataW'(!side3_r.neg);
    wrapped = (side3_r.neg ? (~plo + 1'b1) : plo) & mask;
    if (side3_r.sgn) begin
      ovf = (phi != '0) || (plo > limit);
    end else begin
      ovf = (phi != '0) || ((plo & ~mask) != '0);
    end
    side4_nxt = side3_r;
    if (side3_r.op == OP_MUL) begin
      side4_nxt.res   = wrapped;
      side4_nxt.cause = ovf ? CAUSE_RANGE : CAUSE_NONE;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    side1_r <= in_side;
    a1_r    <= in_a;
    b1_r    <= in_b;
    pp00_r  <= pp00_nxt;
    pp01_r  <= pp01_nxt;
    pp10_r  <= pp10_nxt;
    pp11_r  <= pp11_nxt;
    side2_r <= side1_r;
    a2_r    <= a1_r;
    b2_r    <= b1_r;
    mid_r   <= mid_nxt;
    outer_r <= {pp11_r, pp00_r};
    side3_r <= side2_r;
    a3_r    <= a2_r;
    b3_r    <= b2_r;
    prod_r  <= prod_nxt;
    side4_r <= side4_nxt;
    a4_r    <= a3_r;
    b4_r    <= b3_r;
  end

  assign out_vld  = vld4_r;
  assign out_side = side4_r;
  assign out_a    = a4_r;
  assign out_b    = b4_r;

endmodule

@@ rtl/core/cia_div_pipe.sv @@
module cia_div_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  cia_pkg::cia_side_t          in_side,
  input  logic [cia_pkg::DataW-1:0]   in_dividend,
  input  logic [cia_pkg::DataW-1:0]   in_divisor,
  output logic                        out_vld,
  output cia_pkg::cia_side_t          out_side,
  output logic [cia_pkg::DataW-1:0]   out_quot
);
  import cia_pkg::*;

  localparam int Stages = DataW;

  logic             vld_r  [Stages];
  cia_side_t        side_r [Stages];
  logic [DataW-1:0] rem_r  [Stages];
  logic [DataW-1:0] dq_r   [Stages];
  logic [DataW-1:0] dvs_r  [Stages];

  logic             vin   [Stages];
  cia_side_t        sin   [Stages];
  logic [DataW-1:0] rin   [Stages];
  logic [DataW-1:0] dqin  [Stages];
  logic [DataW-1:0] dvin  [Stages];
  logic [DataW:0]   trial [Stages];
  logic [DataW:0]   diff  [Stages];

  // one restoring quotient bit per stage, msb first
  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) begin
        vin[k]  = in_vld;
        sin[k]  = in_side;
        rin[k]  = '0;
        dqin[k] = in_dividend;
        dvin[k] = in_divisor;
      end else begin
        vin[k]  = vld_r[k-1];
        sin[k]  = side_r[k-1];
        rin[k]  = rem_r[k-1];
        dqin[k] = dq_r[k-1];
        dvin[k] = dvs_r[k-1];
      end
      trial[k] = {rin[k], dqin[k][DataW-1]};
      diff[k]  = trial[k] - {1'b0, dvin[k]};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    for (int k = 0; k < Stages; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin[k];
      end
    end
  end

  // partial remainder, dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    for (int k = 0; k < Stages; k++) begin
      side_r[k] <= sin[k];
      dvs_r[k]  <= dvin[k];
      rem_r[k]  <= diff[k][DataW] ? trial[k][DataW-1:0] : diff[k][DataW-1:0];
      dq_r[k]   <= {dqin[k][DataW-2:0], ~diff[k][DataW]};
    end
  end

  assign out_vld  = vld_r[Stages-1];
  assign out_side = side_r[Stages-1];
  assign out_quot = dq_r[Stages-1];

endmodule
